FILE: rtl/fdaf_pkg.sv
package fdaf_pkg;

  // sample width and derived widths
  localparam int ACCEL_BITS = 14;
  localparam int THR_BITS   = 14;
  localparam int OFFS_BITS  = 14;
  localparam int TICK_BITS  = 16;
  localparam int DIFF_BITS  = ((ACCEL_BITS > OFFS_BITS) ? ACCEL_BITS : OFFS_BITS) + 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  // item kinds
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_ACK    = 2'd2;

  // alert request codes
  localparam logic [1:0] ALERT_NONE   = 2'd0;
  localparam logic [1:0] ALERT_FALL   = 2'd1;
  localparam logic [1:0] ALERT_SEVERE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_THR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEV_THR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV_OFFS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_ON    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_OFF   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEV_ON     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEV_OFF    = 3'd6;

  // register reset values
  localparam logic [THR_BITS-1:0]         RST_FALL_THR  = 14'd1000;
  localparam logic [THR_BITS-1:0]         RST_SEV_THR   = 14'd2000;
  localparam logic signed [OFFS_BITS-1:0] RST_GRAV_OFFS = 14'sd4096;
  localparam logic [TICK_BITS-1:0]        RST_FALL_ON   = 16'd500;
  localparam logic [TICK_BITS-1:0]        RST_FALL_OFF  = 16'd400;
  localparam logic [TICK_BITS-1:0]        RST_SEV_ON    = 16'd250;
  localparam logic [TICK_BITS-1:0]        RST_SEV_OFF   = 16'd150;

  // operating modes
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_MON       = 3'd1,
    MODE_FALL_PEND = 3'd2,
    MODE_SEV_PEND  = 3'd3,
    MODE_FALL      = 3'd4,
    MODE_SEV       = 3'd5
  } mode_e;

  typedef struct packed {
    logic [THR_BITS-1:0]         fall_threshold;
    logic [THR_BITS-1:0]         severe_threshold;
    logic signed [OFFS_BITS-1:0] gravity_offset;
    logic [TICK_BITS-1:0]        fall_on_ticks;
    logic [TICK_BITS-1:0]        fall_off_ticks;
    logic [TICK_BITS-1:0]        severe_on_ticks;
    logic [TICK_BITS-1:0]        severe_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [ACCEL_BITS-1:0] accel_x;
    logic signed [ACCEL_BITS-1:0] accel_y;
    logic signed [ACCEL_BITS-1:0] accel_z;
    logic                         grip_left;
    logic                         grip_right;
  } item_t;

  typedef struct packed {
    logic severe;
    logic fall;
  } eval_t;

endpackage

FILE: rtl/fdaf_cfg_regs.sv
module fdaf_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fdaf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [fdaf_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  output fdaf_pkg::cfg_t                     cfg_o
);

  fdaf_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fdaf_pkg::CFG_FALL_THR:  cfg_d.fall_threshold   = cfg_wdata_i[fdaf_pkg::THR_BITS-1:0];
        fdaf_pkg::CFG_SEV_THR:   cfg_d.severe_threshold = cfg_wdata_i[fdaf_pkg::THR_BITS-1:0];
        fdaf_pkg::CFG_GRAV_OFFS: cfg_d.gravity_offset   = cfg_wdata_i[fdaf_pkg::OFFS_BITS-1:0];
        fdaf_pkg::CFG_FALL_ON:   cfg_d.fall_on_ticks    = cfg_wdata_i[fdaf_pkg::TICK_BITS-1:0];
        fdaf_pkg::CFG_FALL_OFF:  cfg_d.fall_off_ticks   = cfg_wdata_i[fdaf_pkg::TICK_BITS-1:0];
        fdaf_pkg::CFG_SEV_ON:    cfg_d.severe_on_ticks  = cfg_wdata_i[fdaf_pkg::TICK_BITS-1:0];
        fdaf_pkg::CFG_SEV_OFF:   cfg_d.severe_off_ticks = cfg_wdata_i[fdaf_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fall_threshold   <= fdaf_pkg::RST_FALL_THR;
      cfg_q.severe_threshold <= fdaf_pkg::RST_SEV_THR;
      cfg_q.gravity_offset   <= fdaf_pkg::RST_GRAV_OFFS;
      cfg_q.fall_on_ticks    <= fdaf_pkg::RST_FALL_ON;
      cfg_q.fall_off_ticks   <= fdaf_pkg::RST_FALL_OFF;
      cfg_q.severe_on_ticks  <= fdaf_pkg::RST_SEV_ON;
      cfg_q.severe_off_ticks <= fdaf_pkg::RST_SEV_OFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/fdaf_eval.sv
module fdaf_eval (
  input  fdaf_pkg::item_t item_i,
  input  fdaf_pkg::cfg_t  cfg_i,
  output fdaf_pkg::eval_t eval_o
);

  localparam int DB = fdaf_pkg::DIFF_BITS;

  function automatic logic [DB-1:0] abs_val(input logic signed [DB-1:0] v);
    logic [DB-1:0] r;
    begin
      r = v[DB-1] ? DB'(-v) : DB'(v);
      return r;
    end
  endfunction

  logic signed [DB-1:0] x_ext, y_ext, z_diff;
  logic [DB-1:0]        ax, ay, az, fall_thr, sev_thr;

  // axis magnitudes, z relative to resting gravity
  assign x_ext  = DB'(item_i.accel_x);
  assign y_ext  = DB'(item_i.accel_y);
  assign z_diff = DB'(item_i.accel_z) - DB'(cfg_i.gravity_offset);
  assign ax     = abs_val(x_ext);
  assign ay     = abs_val(y_ext);
  assign az     = abs_val(z_diff);

  // threshold compares
  assign fall_thr = DB'(cfg_i.fall_threshold);
  assign sev_thr  = DB'(cfg_i.severe_threshold);
  assign eval_o.severe = (ax > sev_thr) || (ay > sev_thr) || (az > sev_thr);
  assign eval_o.fall   = (ax > fall_thr) || (ay > fall_thr) || (az > fall_thr);

endmodule

FILE: rtl/fdaf_core.sv
module fdaf_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  fdaf_pkg::item_t item_i,
  input  fdaf_pkg::cfg_t  cfg_i,
  input  fdaf_pkg::eval_t eval_i,
  output logic            advance_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      mode_o,
  output logic            led_o,
  output logic [1:0]      alert_request_o
);

  fdaf_pkg::mode_e mode_q, mode_d;
  logic [fdaf_pkg::TICK_BITS-1:0] cnt_q, cnt_d, cnt_inc, limit;
  logic phase_q, phase_d, led_q, led_d;
  logic out_valid_q;
  logic [2:0] mode_out_q;
  logic led_out_q;
  logic [1:0] alert_out_q, alert_d;
  logic fire, both;

  // output register frees when empty or taken
  assign advance_o = !out_valid_q || !out_stall_i;
  assign fire      = in_valid_i && advance_o;
  assign both      = item_i.grip_left && item_i.grip_right;

  // blink limit for the current phase
  always_comb begin
    if (mode_q == fdaf_pkg::MODE_FALL) begin
      limit = phase_q ? cfg_i.fall_on_ticks : cfg_i.fall_off_ticks;
    end else begin
      limit = phase_q ? cfg_i.severe_on_ticks : cfg_i.severe_off_ticks;
    end
  end

  assign cnt_inc = cnt_q + 1'b1;

  // mode and blink next state
  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    led_d   = led_q;
    case (mode_q)
      fdaf_pkg::MODE_IDLE: begin
        led_d = 1'b0;
        if (item_i.func == fdaf_pkg::FUNC_SAMPLE && both) mode_d = fdaf_pkg::MODE_MON;
      end
      fdaf_pkg::MODE_MON: begin
        led_d = 1'b1;
        if (item_i.func == fdaf_pkg::FUNC_SAMPLE && !both) begin
          if (eval_i.severe) mode_d = fdaf_pkg::MODE_SEV_PEND;
          else if (eval_i.fall) mode_d = fdaf_pkg::MODE_FALL_PEND;
        end
      end
      fdaf_pkg::MODE_FALL_PEND, fdaf_pkg::MODE_SEV_PEND: begin
        if (item_i.func == fdaf_pkg::FUNC_ACK) begin
          mode_d  = (mode_q == fdaf_pkg::MODE_FALL_PEND) ? fdaf_pkg::MODE_FALL
                                                          : fdaf_pkg::MODE_SEV;
          cnt_d   = '0;
          phase_d = 1'b1;
          led_d   = 1'b1;
        end
      end
      fdaf_pkg::MODE_FALL, fdaf_pkg::MODE_SEV: begin
        if (item_i.func == fdaf_pkg::FUNC_TICK) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= limit) begin
            phase_d = !phase_q;
            led_d   = !phase_q;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        mode_d = fdaf_pkg::MODE_IDLE;
        led_d  = 1'b0;
      end
    endcase
  end

  // alert request follows the new mode
  always_comb begin
    case (mode_d)
      fdaf_pkg::MODE_FALL_PEND: alert_d = fdaf_pkg::ALERT_FALL;
      fdaf_pkg::MODE_SEV_PEND:  alert_d = fdaf_pkg::ALERT_SEVERE;
      default:                  alert_d = fdaf_pkg::ALERT_NONE;
    endcase
  end

  // state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= fdaf_pkg::MODE_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b1;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire || (out_valid_q && out_stall_i);
      if (fire) begin
        mode_q  <= mode_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        led_q   <= led_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      mode_out_q  <= mode_d;
      led_out_q   <= led_d;
      alert_out_q <= alert_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = mode_out_q;
  assign led_o           = led_out_q;
  assign alert_request_o = alert_out_q;

endmodule

FILE: rtl/fall_detect_alert_fsm.sv
// Fall detection and alert controller for a handlebar unit.
// Input channel (in_valid_i / in_stall_o) carries one beat per event: a
// sensor sample with three acceleration axes and two grip flags, a
// millisecond tick, or an alert-sent acknowledgement, chosen by func_i.
// Output channel (out_valid_o / out_stall_i) returns one beat per input
// beat with the mode, the LED drive and the alert request after that event.
// Thresholds, gravity offset and blink on/off tick counts are written
// through cfg_we_i / cfg_index_i / cfg_wdata_i; the user must write them
// only while the block is idle, which the block itself does not enforce.
// An accepted beat is held in the input register, then the compares and
// the state update are written into the result register. Throughput is
// one beat per cycle while the output is not stalled.
// A stall on the output holds the result; the input register still takes
// one more beat, then in_stall_o rises until the result is taken.
// Reset clears both channels, loads the default register values and
// returns the core to idle with its LED state off and the blink phase on;
// the mode, LED and alert result registers are not reset.
module fall_detect_alert_fsm (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fdaf_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [fdaf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             func_i,
  input  logic signed [fdaf_pkg::ACCEL_BITS-1:0] accel_x_i,
  input  logic signed [fdaf_pkg::ACCEL_BITS-1:0] accel_y_i,
  input  logic signed [fdaf_pkg::ACCEL_BITS-1:0] accel_z_i,
  input  logic                                   grip_left_i,
  input  logic                                   grip_right_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [2:0]                             mode_o,
  output logic                                   led_o,
  output logic [1:0]                             alert_request_o
);

  fdaf_pkg::cfg_t  cfg;
  fdaf_pkg::item_t item_q;
  fdaf_pkg::eval_t eval;
  logic in_valid_q, advance, load;

  // input register handshake
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.func       <= func_i;
      item_q.accel_x    <= accel_x_i;
      item_q.accel_y    <= accel_y_i;
      item_q.accel_z    <= accel_z_i;
      item_q.grip_left  <= grip_left_i;
      item_q.grip_right <= grip_right_i;
    end
  end

  fdaf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fdaf_eval u_eval (
    .item_i (item_q),
    .cfg_i  (cfg),
    .eval_o (eval)
  );

  fdaf_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_q),
    .item_i          (item_q),
    .cfg_i           (cfg),
    .eval_i          (eval),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_o          (mode_o),
    .led_o           (led_o),
    .alert_request_o (alert_request_o)
  );

endmodule
